// ===== rtl/uds_pkg.sv =====
`timescale 1ns / 1ps

package uds_pkg;

    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] MASK_4B = 8'hf8;
    localparam logic [7:0] LEAD_4B = 8'hf0;
    localparam logic [7:0] MASK_3B = 8'hf0;
    localparam logic [7:0] LEAD_3B = 8'he0;
    localparam logic [7:0] MASK_2B = 8'he0;
    localparam logic [7:0] LEAD_2B = 8'hc0;

    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_D = 8'h64;
    localparam logic [7:0] LETTER_E = 8'h65;
    localparam logic [7:0] LETTER_I = 8'h69;
    localparam logic [7:0] LETTER_O = 8'h6f;
    localparam logic [7:0] LETTER_U = 8'h75;
    localparam logic [7:0] LETTER_Y = 8'h79;

    typedef struct packed {
        logic [1:0]      n;
        logic            eos;
        logic [2:0][7:0] data;
    } res_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } q_entry_t;

    function automatic logic [2:0] frame_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & MASK_4B) == LEAD_4B)
        begin
            len = 3'd4;
        end
        else if ((b & MASK_3B) == LEAD_3B)
        begin
            len = 3'd3;
        end
        else if ((b & MASK_2B) == LEAD_2B)
        begin
            len = 3'd2;
        end
        else
        begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic [7:0] lookup_cp(input logic [15:0] cp, input logic [7:0] fb);
        logic [7:0] r;
        r = fb;
        if (cp >= 16'h1ea0 && cp <= 16'h1ef9)
        begin
            if (cp <= 16'h1eb7)
            begin
                r = LETTER_A;
            end
            else if (cp <= 16'h1ec7)
            begin
                r = LETTER_E;
            end
            else if (cp <= 16'h1ecb)
            begin
                r = LETTER_I;
            end
            else if (cp <= 16'h1ee3)
            begin
                r = LETTER_O;
            end
            else if (cp <= 16'h1ef1)
            begin
                r = LETTER_U;
            end
            else
            begin
                r = LETTER_Y;
            end
        end
        else
        begin
            case (cp) inside
                16'h00e1, 16'h00e0, 16'h00e3, 16'h00e2, 16'h0103,
                16'h00c1, 16'h00c0, 16'h00c3, 16'h00c2, 16'h0102: r = LETTER_A;
                16'h0111, 16'h0110: r = LETTER_D;
                16'h00e9, 16'h00e8, 16'h00ea, 16'h00c9, 16'h00c8, 16'h00ca: r = LETTER_E;
                16'h00ed, 16'h00ec, 16'h0129, 16'h00cd, 16'h00cc, 16'h0128: r = LETTER_I;
                16'h00f3, 16'h00f2, 16'h00f5, 16'h00f4, 16'h01a1,
                16'h00d3, 16'h00d2, 16'h00d5, 16'h00d4, 16'h01a0: r = LETTER_O;
                16'h00fa, 16'h00f9, 16'h0169, 16'h01b0,
                16'h00da, 16'h00d9, 16'h0168, 16'h01af: r = LETTER_U;
                16'h00fd, 16'h00dd: r = LETTER_Y;
                default: r = fb;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] map_seq(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [2:0] len);
        logic [15:0] cp;
        logic [7:0]  r;
        r  = b0;
        cp = '0;
        if (len == 3'd2)
        begin
            cp = {5'd0, b0[4:0], b1[5:0]};
            if (b1[7:6] == CONT_TAG && cp >= 16'h0080)
            begin
                r = lookup_cp(cp, b0);
            end
        end
        else if (len == 3'd3)
        begin
            cp = {b0[3:0], b1[5:0], b2[5:0]};
            if (b1[7:6] == CONT_TAG && b2[7:6] == CONT_TAG && cp >= 16'h0800)
            begin
                r = lookup_cp(cp, b0);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/uds_step.sv =====
`timescale 1ns / 1ps

module uds_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_string,
    output uds_pkg::res_t    res
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [2:0] exp_reg;
    logic [2:0] exp_next;

    logic [2:0] len_in;
    logic [1:0] cnt_mid;
    logic [7:0] sb1;
    logic [7:0] sb2;

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        res       = '0;
        res.eos   = end_of_string;
        len_in    = uds_pkg::frame_len(in_byte);
        sb1       = (cnt_reg == 2'd1) ? in_byte : held_reg[1];
        sb2       = (cnt_reg == 2'd2) ? in_byte : held_reg[2];
        cnt_mid   = cnt_reg;

        if (cnt_reg == 2'd0)
        begin
            if (len_in == 3'd1)
            begin
                res.n       = 2'd1;
                res.data[0] = in_byte;
            end
            else
            begin
                held_next[0] = in_byte;
                cnt_mid      = 2'd1;
                exp_next     = len_in;
            end
        end
        else if ({1'b0, cnt_reg} + 3'd1 >= exp_reg)
        begin
            res.n       = 2'd1;
            res.data[0] = uds_pkg::map_seq(held_reg[0], sb1, sb2, exp_reg);
            cnt_mid     = 2'd0;
            exp_next    = 3'd1;
        end
        else
        begin
            held_next[cnt_reg] = in_byte;
            cnt_mid            = cnt_reg + 2'd1;
        end

        cnt_next = cnt_mid;

        // reframe an open sequence cut short by the end of the string
        if (end_of_string && cnt_mid != 2'd0)
        begin
            res.data[0] = held_next[0];
            res.data[1] = held_next[1];
            res.data[2] = held_next[2];
            res.n       = cnt_mid;
            if (cnt_mid == 2'd3 && uds_pkg::frame_len(held_next[1]) == 3'd2)
            begin
                res.n       = 2'd2;
                res.data[1] = uds_pkg::map_seq(held_next[1], held_next[2], 8'd0, 3'd2);
            end
            cnt_next = 2'd0;
            exp_next = 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            exp_reg <= 3'd1;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

`ifndef ASSERT_OFF
    a_open_seq_longer: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> (exp_reg > {1'b0, cnt_reg}))
        else $error("open sequence not shorter than its lead length");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_string) |=> (cnt_reg == 2'd0 && exp_reg == 3'd1))
        else $error("framing state not cleared after end of string");
`endif

endmodule

// ===== rtl/utf8_diacritic_stripper.sv =====
`timescale 1ns / 1ps
// A result beat enters the output queue when the input beat that causes it is accepted.
// Throughput: one byte per cycle unless stalled; an opening or extending beat gives no result.
// A string that ends inside an open sequence gives up to three result beats; input
// stalls while more than one result waits in the four-entry output queue.
// Reset (rst_n low, asynchronous) clears the framing state and empties the queue.

module utf8_diacritic_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // string_done
);

    uds_pkg::res_t     res;
    logic              push;
    logic              pop;
    logic [uds_pkg::Q_CNT_W-1:0] base;
    logic [uds_pkg::Q_CNT_W-1:0] n_push;
    logic [uds_pkg::Q_CNT_W-1:0] off;
    uds_pkg::q_entry_t new_ent [uds_pkg::MAX_RES];
    uds_pkg::q_entry_t sh [uds_pkg::Q_DEPTH];
    uds_pkg::q_entry_t q_reg [uds_pkg::Q_DEPTH];
    uds_pkg::q_entry_t q_next [uds_pkg::Q_DEPTH];
    logic [uds_pkg::Q_CNT_W-1:0] q_cnt_reg;
    logic [uds_pkg::Q_CNT_W-1:0] q_cnt_next;

    assign s_tready = (q_cnt_reg <= uds_pkg::Q_CNT_W'(1));
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = q_reg[0].out_byte;
    assign m_tlast  = q_reg[0].run_last;
    assign m_tuser  = q_reg[0].string_done;

    assign push = s_tvalid & s_tready;
    assign pop  = m_tvalid & m_tready;

    uds_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (push),
        .in_byte       (s_tdata),
        .end_of_string (s_tlast),
        .res           (res)
    );

    always_comb
    begin
        for (int k = 0; k < uds_pkg::MAX_RES; k++)
        begin
            new_ent[k].out_byte    = res.data[k];
            new_ent[k].run_last    = (uds_pkg::Q_CNT_W'(k + 1) == uds_pkg::Q_CNT_W'(res.n));
            new_ent[k].string_done = new_ent[k].run_last & res.eos;
        end

        for (int i = 0; i < uds_pkg::Q_DEPTH - 1; i++)
        begin
            sh[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        sh[uds_pkg::Q_DEPTH - 1] = q_reg[uds_pkg::Q_DEPTH - 1];

        base   = q_cnt_reg - uds_pkg::Q_CNT_W'(pop);
        n_push = push ? uds_pkg::Q_CNT_W'(res.n) : '0;
        off    = '0;

        for (int i = 0; i < uds_pkg::Q_DEPTH; i++)
        begin
            q_next[i] = sh[i];
            off       = uds_pkg::Q_CNT_W'(i) - base;
            if (uds_pkg::Q_CNT_W'(i) >= base && off < n_push)
            begin
                q_next[i] = new_ent[off[1:0]];
            end
        end

        q_cnt_next = base + n_push;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= uds_pkg::Q_CNT_W'(uds_pkg::Q_DEPTH))
        else $error("output queue overflow");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("string end beat not marked last of its run");
`endif

endmodule
